[sv/ansi_terminal_interpreter_top_macros.svh]
// Assertion macros for the terminal interpreter.
`ifndef ANSI_TERMINAL_INTERPRETER_TOP_MACROS_SVH
`define ANSI_TERMINAL_INTERPRETER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define ATI_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define ATI_ASSERT_NR(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ATI_ASSERT(label, clk, rst, prop)
`define ATI_ASSERT_NR(label, clk, prop)
`endif
`endif

[sv/ati_pkg.sv]
// ----------------------------------------------------------------------------
// ati_pkg
// Types and constants shared by the terminal interpreter modules.
// ----------------------------------------------------------------------------
package ati_pkg;
   localparam int ArgSlotsDef = 3;
   localparam int ArgWidthDef = 16;
   localparam int MaxResults  = 5;
   localparam int CntW        = 3;

   typedef enum logic [2:0] {
      MODE_NORMAL = 3'd0,
      MODE_ESC    = 3'd1,
      MODE_CSI    = 3'd2,
      MODE_PRV    = 3'd3,
      MODE_BAD    = 3'd4
   } mode_type;

   localparam logic [2:0] CMD_DRAW   = 3'd0;
   localparam logic [2:0] CMD_COPY   = 3'd1;
   localparam logic [2:0] CMD_ERASE  = 3'd2;
   localparam logic [2:0] CMD_BELL   = 3'd3;
   localparam logic [2:0] CMD_CURSOR = 3'd4;
   localparam logic [2:0] CMD_UNCUR  = 3'd5;

   localparam logic [1:0] REG_LINES = 2'd0;
   localparam logic [1:0] REG_COLS  = 2'd1;
   localparam logic [1:0] REG_FG    = 2'd2;
   localparam logic [1:0] REG_BG    = 2'd3;

   localparam logic [7:0] LinesRst = 8'd25;
   localparam logic [7:0] ColsRst  = 8'd80;
   localparam logic [7:0] FgRst    = 8'd7;
   localparam logic [7:0] BgRst    = 8'd0;

   localparam logic [7:0] PrvCursor = 8'd25;
   localparam logic [7:0] PrvWrap   = 8'd7;
   localparam logic [7:0] RevLast   = 8'd19;
   localparam logic [7:0] ChBel = 8'h07;
   localparam logic [7:0] ChBs  = 8'h08;
   localparam logic [7:0] ChLf  = 8'h0A;
   localparam logic [7:0] ChCr  = 8'h0D;
   localparam logic [7:0] ChEsc = 8'h1B;
   localparam logic [7:0] ChCsi = 8'h9B;

   typedef struct packed {
      logic [2:0] cmd;
      logic [7:0] line;
      logic [7:0] column;
      logic [7:0] dest_line;
      logic [7:0] n_lines;
      logic [7:0] n_cols;
      logic [7:0] glyph;
      logic [7:0] color;
      logic       reverse;
   } cmd_type;

   typedef struct packed {
      logic [7:0] lines;
      logic [7:0] cols;
      logic [7:0] fg;
      logic [7:0] bg;
   } cfg_type;
endpackage

[sv/ati_core.sv]
// ----------------------------------------------------------------------------
// ati_core
// Parser state and the command list for one byte, computed in one pass.
// ----------------------------------------------------------------------------
module ati_core #(
   parameter int ARG_SLOTS = ati_pkg::ArgSlotsDef,
   parameter int ARG_WIDTH = ati_pkg::ArgWidthDef
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  step,
   input  logic [7:0]                            char_code,
   input  ati_pkg::cfg_type                      cfg,
   output ati_pkg::cmd_type [ati_pkg::MaxResults-1:0] cmds,
   output logic [ati_pkg::CntW-1:0]              count
);
   localparam int IdxW = (ARG_SLOTS > 1) ? $clog2(ARG_SLOTS) : 1;
   localparam logic [ARG_WIDTH-1:0] ArgMax = '1;

   ati_pkg::mode_type mode_ff, mode_in;
   logic arg_seen_ff, arg_seen_in;
   logic [ARG_WIDTH-1:0] args_ff [ARG_SLOTS];
   logic [ARG_WIDTH-1:0] args_in [ARG_SLOTS];
   logic [IdxW-1:0] idx_ff, idx_in;
   logic [7:0] cl_ff, cl_in, cc_ff, cc_in;
   logic pw_ff, pw_in, aw_ff, aw_in, ce_ff, ce_in, cs_ff, cs_in, rv_ff, rv_in;

   ati_pkg::cmd_type [ati_pkg::MaxResults-1:0] list;
   logic [ati_pkg::CntW-1:0] n;

   logic [7:0] lines, cols, lm1, cm1;
   logic [ARG_WIDTH-1:0] a0, a1, cur;
   logic [ARG_WIDTH+3:0] prod;
   logic [ARG_WIDTH:0] tsum;
   logic [7:0] room;
   logic printable;

   always_comb begin
      lines = (cfg.lines == 8'd0) ? 8'd1 : cfg.lines;
      cols  = (cfg.cols == 8'd0) ? 8'd1 : cfg.cols;
      lm1 = lines - 8'd1;
      cm1 = cols - 8'd1;
      a0 = (args_ff[0] == '0) ? ARG_WIDTH'(1) : args_ff[0];
      a1 = (idx_ff < IdxW'(1) || args_ff[1] == '0) ? ARG_WIDTH'(1) : args_ff[1];
      cur = args_ff[idx_ff];
      prod = {4'd0, cur} * (ARG_WIDTH+4)'(10) + (ARG_WIDTH+4)'(char_code[3:0]);
      tsum = {1'b0, ARG_WIDTH'(cc_ff)} + {1'b0, a0};
      room = lm1 - cl_ff;
      printable = (char_code >= 8'h20) && (char_code <= 8'h7E);
   end

   // Sequential emulation of the step; each stage is short and narrow.
   always_comb begin
      ati_pkg::cmd_type c;
      logic do_lf, do_cr, do_glyph;
      logic [7:0] r8, k8;
      mode_in = mode_ff; arg_seen_in = arg_seen_ff; args_in = args_ff;
      idx_in = idx_ff; cl_in = cl_ff; cc_in = cc_ff; pw_in = pw_ff; aw_in = aw_ff;
      ce_in = ce_ff; cs_in = cs_ff; rv_in = rv_ff;
      list = '0; n = '0; c = '0; do_lf = 1'b0; do_cr = 1'b0; do_glyph = 1'b0;
      r8 = '0; k8 = '0;

      c.line = cl_ff; c.column = cc_ff; c.color = cfg.fg; c.reverse = rv_ff;
      c.cmd = ati_pkg::CMD_UNCUR;
      // "hide" is placed at slot 0 if needed; later code recomputes as needed
      if (printable) begin
         case (mode_ff)
            ati_pkg::MODE_ESC: begin
               if (char_code == "[") begin
                  mode_in = ati_pkg::MODE_CSI; idx_in = '0; args_in[0] = '0;
                  arg_seen_in = 1'b0;
               end else mode_in = ati_pkg::MODE_NORMAL;
            end
            ati_pkg::MODE_BAD: mode_in = ati_pkg::MODE_NORMAL;
            ati_pkg::MODE_CSI: begin
               case (char_code)
                  "A": begin
                     if (cl_ff != 8'd0) begin
                        if (cs_ff && ce_ff) begin list[n] = c; n = n + 1'b1; cs_in = 1'b0; end
                        cl_in = (a0 >= ARG_WIDTH'(cl_ff)) ? 8'd0 : cl_ff - a0[7:0];
                     end
                     mode_in = ati_pkg::MODE_NORMAL; pw_in = 1'b0;
                  end
                  "B": begin
                     if (cl_ff < lm1) begin
                        if (cs_ff && ce_ff) begin list[n] = c; n = n + 1'b1; cs_in = 1'b0; end
                        cl_in = cl_ff + ((a0 >= ARG_WIDTH'(room)) ? room : a0[7:0]);
                     end
                     mode_in = ati_pkg::MODE_NORMAL; pw_in = 1'b0;
                  end
                  "C": begin
                     if (cc_ff < cm1) begin
                        if (cs_ff && ce_ff) begin list[n] = c; n = n + 1'b1; cs_in = 1'b0; end
                        cc_in = (tsum > (ARG_WIDTH+1)'(cm1)) ? cm1 : tsum[7:0];
                     end
                     mode_in = ati_pkg::MODE_NORMAL; pw_in = 1'b0;
                  end
                  "D": begin
                     if (cc_ff != 8'd0) begin
                        if (cs_ff && ce_ff) begin list[n] = c; n = n + 1'b1; cs_in = 1'b0; end
                        cc_in = (ARG_WIDTH'(cc_ff) < a0) ? 8'd0 : cc_ff - a0[7:0];
                     end
                     mode_in = ati_pkg::MODE_NORMAL; pw_in = 1'b0;
                  end
                  "H": begin
                     r8 = ((a0 - 1'b1) >= ARG_WIDTH'(lines)) ? lm1 : 8'(a0 - 1'b1);
                     k8 = ((a1 - 1'b1) >= ARG_WIDTH'(cols)) ? cm1 : 8'(a1 - 1'b1);
                     if (r8 != cl_ff || k8 != cc_ff) begin
                        if (cs_ff && ce_ff) begin list[n] = c; n = n + 1'b1; cs_in = 1'b0; end
                        cl_in = r8; cc_in = k8;
                     end
                     mode_in = ati_pkg::MODE_NORMAL; pw_in = 1'b0;
                  end
                  "J", "K": begin
                     c = '0; c.cmd = ati_pkg::CMD_ERASE; c.line = cl_ff; c.column = cc_ff;
                     c.n_lines = 8'd1; c.n_cols = (cols > cc_ff) ? cols - cc_ff : 8'd0;
                     c.color = cfg.bg;
                     list[n] = c; n = n + 1'b1;
                     if (char_code == "J" && cl_ff < lm1) begin
                        c.line = cl_ff + 8'd1; c.column = 8'd0;
                        c.n_lines = lm1 - cl_ff; c.n_cols = cols;
                        list[n] = c; n = n + 1'b1;
                     end
                     cs_in = 1'b0; mode_in = ati_pkg::MODE_NORMAL; pw_in = 1'b0;
                  end
                  "m": begin
                     rv_in = (cur >= ARG_WIDTH'(1)) && (cur <= ARG_WIDTH'(ati_pkg::RevLast));
                     mode_in = ati_pkg::MODE_NORMAL;
                  end
                  "?": begin
                     if (!arg_seen_ff) begin
                        mode_in = ati_pkg::MODE_PRV; idx_in = '0; args_in[0] = '0;
                     end else mode_in = ati_pkg::MODE_NORMAL;
                  end
                  ";": begin
                     arg_seen_in = 1'b1;
                     if (32'(idx_ff) < ARG_SLOTS - 1) begin
                        idx_in = idx_ff + 1'b1; args_in[idx_ff + 1'b1] = '0;
                     end
                  end
                  default: begin
                     if (char_code >= "0" && char_code <= "9") begin
                        arg_seen_in = 1'b1;
                        args_in[idx_ff] = (prod > (ARG_WIDTH+4)'(ArgMax)) ? ArgMax
                                          : prod[ARG_WIDTH-1:0];
                     end else mode_in = ati_pkg::MODE_BAD;
                  end
               endcase
            end
            ati_pkg::MODE_PRV: begin
               if (char_code == "h") begin
                  if (args_ff[0] == ARG_WIDTH'(ati_pkg::PrvCursor)) ce_in = 1'b1;
                  else if (args_ff[0] == ARG_WIDTH'(ati_pkg::PrvWrap)) aw_in = 1'b1;
                  mode_in = ati_pkg::MODE_NORMAL;
               end else if (char_code == "l") begin
                  if (args_ff[0] == ARG_WIDTH'(ati_pkg::PrvCursor)) begin
                     if (cs_ff && ce_ff) begin list[n] = c; n = n + 1'b1; cs_in = 1'b0; end
                     ce_in = 1'b0;
                  end else if (args_ff[0] == ARG_WIDTH'(ati_pkg::PrvWrap)) begin
                     pw_in = 1'b0; aw_in = 1'b0;
                  end
                  mode_in = ati_pkg::MODE_NORMAL;
               end else if (char_code == ";") begin
                  arg_seen_in = 1'b1;
                  if (32'(idx_ff) < ARG_SLOTS - 1) begin
                     idx_in = idx_ff + 1'b1; args_in[idx_ff + 1'b1] = '0;
                  end
               end else if (char_code >= "0" && char_code <= "9") begin
                  arg_seen_in = 1'b1;
                  args_in[idx_ff] = (prod > (ARG_WIDTH+4)'(ArgMax)) ? ArgMax
                                    : prod[ARG_WIDTH-1:0];
               end else mode_in = ati_pkg::MODE_BAD;
            end
            default: begin
               mode_in = ati_pkg::MODE_NORMAL; do_glyph = 1'b1;
               if (pw_ff) begin do_cr = 1'b1; do_lf = 1'b1; end
            end
         endcase
      end else begin
         case (char_code)
            ati_pkg::ChBel: begin
               list[n] = '0; list[n].cmd = ati_pkg::CMD_BELL; n = n + 1'b1;
            end
            ati_pkg::ChBs: begin
               if (cc_ff != 8'd0) begin
                  if (cs_ff && ce_ff) begin list[n] = c; n = n + 1'b1; cs_in = 1'b0; end
                  cc_in = cc_ff - 8'd1;
               end
               pw_in = 1'b0;
            end
            ati_pkg::ChLf: begin do_lf = 1'b1; do_cr = 1'b1; end
            ati_pkg::ChCr: do_cr = 1'b1;
            ati_pkg::ChEsc: mode_in = ati_pkg::MODE_ESC;
            ati_pkg::ChCsi: begin
               mode_in = ati_pkg::MODE_CSI; idx_in = '0; args_in[0] = '0;
               arg_seen_in = 1'b0;
            end
            default: ;
         endcase
      end

      // Glyph wrap does CR then LF; LF byte does LF then CR. Order only
      // matters for the hide, which goes with whichever acts first.
      if (do_glyph && do_cr && cc_ff != 8'd0) begin
         if (cs_in && ce_in) begin list[n] = c; n = n + 1'b1; cs_in = 1'b0; end
         cc_in = 8'd0;
      end
      if (do_lf) begin
         if (cl_ff == lm1) begin
            if (cs_in && ce_in) begin list[n] = c; n = n + 1'b1; cs_in = 1'b0; end
            list[n] = '0; list[n].cmd = ati_pkg::CMD_COPY; list[n].line = 8'd1;
            list[n].n_lines = lm1; n = n + 1'b1;
            list[n] = '0; list[n].cmd = ati_pkg::CMD_ERASE; list[n].line = lm1;
            list[n].n_lines = 8'd1; list[n].n_cols = cols; list[n].color = cfg.bg;
            n = n + 1'b1;
         end else if (cl_ff < lines) begin
            if (cs_in && ce_in) begin list[n] = c; n = n + 1'b1; cs_in = 1'b0; end
            cl_in = cl_ff + 8'd1;
         end
         mode_in = ati_pkg::MODE_NORMAL; pw_in = 1'b0;
      end
      if (!do_glyph && do_cr) begin
         if (cc_ff != 8'd0) begin
            if (cs_in && ce_in) begin
               list[n] = c; n = n + 1'b1; cs_in = 1'b0;
            end
            cc_in = 8'd0;
         end
         pw_in = 1'b0;
      end
      if (do_glyph && do_cr) pw_in = 1'b0;
      if (do_glyph) begin
         list[n] = '0; list[n].cmd = ati_pkg::CMD_DRAW; list[n].line = cl_in;
         list[n].column = cc_in; list[n].glyph = char_code; list[n].color = cfg.fg;
         list[n].reverse = rv_ff; n = n + 1'b1;
         cs_in = 1'b0;
         if (cc_in < cm1) cc_in = cc_in + 8'd1;
         else if (aw_ff) pw_in = 1'b1;
      end
      if (!cs_in && ce_in) begin
         list[n] = '0; list[n].cmd = ati_pkg::CMD_CURSOR; list[n].line = cl_in;
         list[n].column = cc_in; list[n].color = cfg.fg; list[n].reverse = rv_in;
         n = n + 1'b1; cs_in = 1'b1;
      end
      cmds = list;
      count = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ati_pkg::MODE_NORMAL; arg_seen_ff <= 1'b0; idx_ff <= '0;
         for (int i = 0; i < ARG_SLOTS; i++) args_ff[i] <= '0;
         cl_ff <= '0; cc_ff <= '0; pw_ff <= 1'b0; aw_ff <= 1'b1;
         ce_ff <= 1'b1; cs_ff <= 1'b0; rv_ff <= 1'b0;
      end else if (step) begin
         mode_ff <= mode_in; arg_seen_ff <= arg_seen_in; idx_ff <= idx_in;
         args_ff <= args_in; cl_ff <= cl_in; cc_ff <= cc_in; pw_ff <= pw_in;
         aw_ff <= aw_in; ce_ff <= ce_in; cs_ff <= cs_in; rv_ff <= rv_in;
      end
   end
endmodule

[sv/ati_outq.sv]
// ----------------------------------------------------------------------------
// ati_outq
// Holds the command list of one byte and sends it one item at a time.
// ----------------------------------------------------------------------------
module ati_outq (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  load,
   input  ati_pkg::cmd_type [ati_pkg::MaxResults-1:0] cmds,
   input  logic [ati_pkg::CntW-1:0]              count,
   output logic                                  free,
   output logic                                  tvalid,
   input  logic                                  tready,
   output ati_pkg::cmd_type                      item,
   output logic                                  tlast
);
   ati_pkg::cmd_type [ati_pkg::MaxResults-1:0] buf_ff;
   logic [ati_pkg::CntW-1:0] cnt_ff, cnt_in, pos_ff, pos_in;
   logic done;

   always_comb begin
      tvalid = cnt_ff != '0;
      item = buf_ff[pos_ff];
      tlast = pos_ff == cnt_ff - 1'b1;
      done = tvalid && tready && tlast;
      free = (cnt_ff == '0) || done;
      cnt_in = cnt_ff; pos_in = pos_ff;
      if (tvalid && tready) pos_in = pos_ff + 1'b1;
      if (done) begin cnt_in = '0; pos_in = '0; end
      if (load) begin cnt_in = count; pos_in = '0; end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0; pos_ff <= '0;
      end else begin
         cnt_ff <= cnt_in; pos_ff <= pos_in;
      end
      if (load) buf_ff <= cmds;
   end
endmodule

[sv/ansi_terminal_interpreter_top.sv]
// The first result item is registered and is presented in the cycle after the byte
// is accepted. Result items go out one per cycle while rsp_tready is high; a byte is
// taken once the previous byte's list (up to five items) is out.
// The output command buffer sets this pace.
// Reset: synchronous, active high; parser, cursor and registers to defaults.
// ----------------------------------------------------------------------------
// ansi_terminal_interpreter_top
// VT100-style escape parser emitting screen commands.
// ----------------------------------------------------------------------------
`include "ansi_terminal_interpreter_top_macros.svh"
module ansi_terminal_interpreter_top #(
   parameter int ARG_SLOTS = ati_pkg::ArgSlotsDef,
   parameter int ARG_WIDTH = ati_pkg::ArgWidthDef
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // char_code
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // cmd, line, column, dest_line, n_lines,
                                    // n_cols, glyph, color, reverse, zero pad
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);
   ati_pkg::cfg_type cfg_ff;
   ati_pkg::cmd_type [ati_pkg::MaxResults-1:0] cmds;
   ati_pkg::cmd_type item;
   logic [ati_pkg::CntW-1:0] count;
   logic free, step;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{ati_pkg::LinesRst, ati_pkg::ColsRst, ati_pkg::FgRst, ati_pkg::BgRst};
      end else if (csr_we) begin
         case (csr_index)
            ati_pkg::REG_LINES: cfg_ff.lines <= csr_wdata;
            ati_pkg::REG_COLS:  cfg_ff.cols  <= csr_wdata;
            ati_pkg::REG_FG:    cfg_ff.fg    <= csr_wdata;
            ati_pkg::REG_BG:    cfg_ff.bg    <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_tready = free;
   assign step = req_tvalid && req_tready;

   ati_core #(.ARG_SLOTS(ARG_SLOTS), .ARG_WIDTH(ARG_WIDTH)) u_core (
      .clock(clock), .reset(reset), .step(step), .char_code(req_tdata),
      .cfg(cfg_ff), .cmds(cmds), .count(count));

   ati_outq u_outq (
      .clock(clock), .reset(reset), .load(step), .cmds(cmds), .count(count),
      .free(free), .tvalid(rsp_tvalid), .tready(rsp_tready), .item(item),
      .tlast(rsp_tlast));

   assign rsp_tdata = {4'd0, item.reverse, item.color, item.glyph, item.n_cols,
                       item.n_lines, item.dest_line, item.column, item.line, item.cmd};

   `ATI_ASSERT(a_cmd_range, clock, reset, rsp_tvalid |-> rsp_tdata[2:0] <= 3'd5)
   `ATI_ASSERT(a_no_accept_busy, clock, reset, (rsp_tvalid && !rsp_tready) |-> !req_tready)
   `ATI_ASSERT(a_dest_zero, clock, reset, rsp_tvalid |-> rsp_tdata[26:19] == 8'd0)
endmodule
